[hw/rtl/i2ra_pkg.sv]
// shared types, constants and digit encoding for the radix ascii converter
`default_nettype none
package i2ra_pkg;

	localparam int unsigned VALUE_BITS    = 64;
	localparam int unsigned SYMBOL_WIDTH  = 7;
	localparam int unsigned TDATA_OUT_W   = 8;
	localparam int unsigned RADIX_WIDTH   = 5;
	localparam int unsigned DIGIT_WIDTH   = 4;
	localparam int unsigned BITS_PER_STEP = 4;

	localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = 5'd10;
	localparam logic [RADIX_WIDTH-1:0] RADIX_MIN   = 5'd2;
	localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = 5'd16;

	localparam logic [SYMBOL_WIDTH-1:0] ASCII_ZERO   = 7'h30;
	localparam logic [SYMBOL_WIDTH-1:0] ASCII_LOWER_A = 7'h61;
	localparam logic [DIGIT_WIDTH-1:0]  DECIMAL_TEN  = 4'd10;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_STORE,
		ST_READ,
		ST_LOAD
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic store;
		logic rd_issue;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic step_last;
		logic quot_zero;
		logic cnt_one;
		logic out_free;
	} status_t;

	function automatic logic [SYMBOL_WIDTH-1:0] digit_to_ascii(input logic [DIGIT_WIDTH-1:0] d);
		logic [SYMBOL_WIDTH-1:0] sym;
		if (d < DECIMAL_TEN) begin
			sym = ASCII_ZERO + {{(SYMBOL_WIDTH-DIGIT_WIDTH){1'b0}}, d};
		end else begin
			sym = ASCII_LOWER_A + {{(SYMBOL_WIDTH-DIGIT_WIDTH){1'b0}}, d - DECIMAL_TEN};
		end
		return sym;
	endfunction

	function automatic logic [RADIX_WIDTH-1:0] effective_radix(input logic [RADIX_WIDTH-1:0] r);
		logic [RADIX_WIDTH-1:0] e;
		if (r < RADIX_MIN) begin
			e = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			e = RADIX_MAX;
		end else begin
			e = r;
		end
		return e;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/i2ra_ram.sv]
// generic single write port ram with registered read
`default_nettype none
module i2ra_ram #(
	parameter int unsigned WIDTH = 4,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[hw/rtl/i2ra_ctrl.sv]
// controller state machine for the radix ascii converter
`default_nettype none
module i2ra_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output      logic              in_ready,
	input  wire i2ra_pkg::status_t status,
	output      i2ra_pkg::cmd_t    cmd
);

	i2ra_pkg::state_t state_q;
	i2ra_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= i2ra_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			i2ra_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = i2ra_pkg::ST_DIV;
				end
			end
			i2ra_pkg::ST_DIV: begin
				cmd.step = 1'b1;
				if (status.step_last) begin
					state_d = i2ra_pkg::ST_STORE;
				end
			end
			i2ra_pkg::ST_STORE: begin
				cmd.store = 1'b1;
				state_d   = status.quot_zero ? i2ra_pkg::ST_READ : i2ra_pkg::ST_DIV;
			end
			i2ra_pkg::ST_READ: begin
				if (status.out_free) begin
					cmd.rd_issue = 1'b1;
					state_d      = i2ra_pkg::ST_LOAD;
				end
			end
			i2ra_pkg::ST_LOAD: begin
				cmd.out_load = 1'b1;
				state_d      = status.cnt_one ? i2ra_pkg::ST_IDLE : i2ra_pkg::ST_READ;
			end
			default: begin
				state_d = i2ra_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

[hw/rtl/i2ra_dp.sv]
// datapath: radix register, digit divider, digit buffer and output register
`default_nettype none
module i2ra_dp #(
	parameter int unsigned VALUE_WIDTH = 64
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_valid,
	input  wire logic [i2ra_pkg::RADIX_WIDTH-1:0]       cfg_data,
	input  wire logic [i2ra_pkg::VALUE_BITS-1:0]        value,
	input  wire logic                                   is_signed,
	input  wire i2ra_pkg::cmd_t                         cmd,
	output      i2ra_pkg::status_t                      status,
	input  wire logic                                   out_ready,
	output      logic                                   out_valid,
	output      logic [i2ra_pkg::SYMBOL_WIDTH-1:0]      out_symbol,
	output      logic                                   out_negative,
	output      logic                                   out_last
);

	localparam int unsigned BPS   = i2ra_pkg::BITS_PER_STEP;
	localparam int unsigned DW    = ((VALUE_WIDTH + BPS - 1) / BPS) * BPS;
	localparam int unsigned STEPS = DW / BPS;
	localparam int unsigned SW    = $clog2(STEPS);
	localparam int unsigned CW    = $clog2(VALUE_WIDTH + 1);
	localparam int unsigned AW    = $clog2(VALUE_WIDTH);
	localparam int unsigned RW    = i2ra_pkg::RADIX_WIDTH;
	localparam int unsigned GW    = i2ra_pkg::DIGIT_WIDTH;

	logic [RW-1:0]          radix_q;
	logic [RW-1:0]          base_q;
	logic                   neg_q;
	logic [DW-1:0]          mag_q;
	logic [GW-1:0]          rem_q;
	logic [SW-1:0]          step_q;
	logic [CW-1:0]          cnt_q;
	logic                   out_valid_q;
	logic [i2ra_pkg::SYMBOL_WIDTH-1:0] out_sym_q;
	logic                   out_neg_q;
	logic                   out_last_q;

	logic [VALUE_WIDTH-1:0] v_in;
	logic                   neg_in;
	logic [VALUE_WIDTH-1:0] mag_in;
	logic [DW-1:0]          mag_next;
	logic [RW-1:0]          rem_next;
	logic [GW-1:0]          rd_digit;
	logic [AW-1:0]          rd_addr;
	logic [CW-1:0]          cnt_dec;

	assign v_in    = value[VALUE_WIDTH-1:0];
	assign neg_in  = is_signed & v_in[VALUE_WIDTH-1];
	assign mag_in  = neg_in ? (~v_in + 1'b1) : v_in;
	assign cnt_dec = cnt_q - 1'b1;
	assign rd_addr = cnt_dec[AW-1:0];

	// four restoring division steps per cycle on a narrow remainder
	always_comb begin
		logic [RW-1:0] r;
		logic [DW-1:0] m;
		r = {1'b0, rem_q};
		m = mag_q;
		for (int i = 0; i < BPS; i++) begin
			r = {r[RW-2:0], m[DW-1]};
			m = {m[DW-2:0], 1'b0};
			if (r >= base_q) begin
				r    = r - base_q;
				m[0] = 1'b1;
			end
		end
		mag_next = m;
		rem_next = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q     <= i2ra_pkg::RADIX_RESET;
			step_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				radix_q <= cfg_data;
			end
			if (cmd.load || cmd.store) begin
				step_q <= '0;
			end else if (cmd.step) begin
				step_q <= step_q + 1'b1;
			end
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.store) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.out_load) begin
				cnt_q <= cnt_dec;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q <= i2ra_pkg::effective_radix(radix_q);
			neg_q  <= neg_in;
			mag_q  <= DW'(mag_in);
			rem_q  <= '0;
		end else if (cmd.step) begin
			mag_q <= mag_next;
			rem_q <= rem_next[GW-1:0];
		end else if (cmd.store) begin
			rem_q <= '0;
		end
		if (cmd.out_load) begin
			out_sym_q  <= i2ra_pkg::digit_to_ascii(rd_digit);
			out_neg_q  <= neg_q;
			out_last_q <= (cnt_q == CW'(1));
		end
	end

	i2ra_ram #(
		.WIDTH(GW),
		.DEPTH(VALUE_WIDTH)
	) u_digits (
		.clk  (clk),
		.we   (cmd.store),
		.waddr(cnt_q[AW-1:0]),
		.wdata(rem_q),
		.re   (cmd.rd_issue),
		.raddr(rd_addr),
		.rdata(rd_digit)
	);

	assign status.step_last = (step_q == SW'(STEPS - 1));
	assign status.quot_zero = (mag_q == '0);
	assign status.cnt_one   = (cnt_q == CW'(1));
	assign status.out_free  = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign out_symbol   = out_sym_q;
	assign out_negative = out_neg_q;
	assign out_last     = out_last_q;

endmodule
`default_nettype wire

[hw/rtl/integer_to_radix_ascii.sv]
// integer to radix 2..16 ascii digits: most significant digit first, last marked
// each digit comes from the 4-bit-per-cycle divider and is then stored into the digit ram
// then each digit is read back from the digit ram into the output register once that register is free
// the next item is taken once the last digit sits in the output register
// arst_n clears the controller and output valid and sets the radix to 10
`default_nettype none
module integer_to_radix_ascii #(
	parameter int unsigned VALUE_WIDTH = 64
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_valid,
	output      logic                                  cfg_ready,
	input  wire logic [i2ra_pkg::RADIX_WIDTH-1:0]      cfg_data,     // radix
	input  wire logic                                  s_axis_tvalid,
	output      logic                                  s_axis_tready,
	input  wire logic [i2ra_pkg::VALUE_BITS-1:0]       s_axis_tdata, // value
	input  wire logic                                  s_axis_tuser, // is_signed
	output      logic                                  m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	output      logic [i2ra_pkg::TDATA_OUT_W-1:0]      m_axis_tdata, // symbol, zero pad
	output      logic                                  m_axis_tuser, // negative
	output      logic                                  m_axis_tlast
);

	i2ra_pkg::cmd_t    cmd;
	i2ra_pkg::status_t status;
	logic [i2ra_pkg::SYMBOL_WIDTH-1:0] symbol;

	assign cfg_ready = 1'b1;

	i2ra_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.status  (status),
		.cmd     (cmd)
	);

	i2ra_dp #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.value       (s_axis_tdata),
		.is_signed   (s_axis_tuser),
		.cmd         (cmd),
		.status      (status),
		.out_ready   (m_axis_tready),
		.out_valid   (m_axis_tvalid),
		.out_symbol  (symbol),
		.out_negative(m_axis_tuser),
		.out_last    (m_axis_tlast)
	);

	assign m_axis_tdata = {{(i2ra_pkg::TDATA_OUT_W-i2ra_pkg::SYMBOL_WIDTH){1'b0}}, symbol};

endmodule
`default_nettype wire

[test/tb_integer_to_radix_ascii.sv]
// self-checking testbench for the integer to radix ascii converter
`default_nettype none
module tb_integer_to_radix_ascii;

	localparam int unsigned LIMIT_CYCLES = 4_000_000;
	localparam int unsigned TAIL_CYCLES  = 1300;
	localparam logic [63:0] MOST_NEGATIVE = {1'b1, 63'd0};
	localparam string DIGIT_SET = "0123456789abcdef";

	typedef logic [i2ra_pkg::SYMBOL_WIDTH-1:0] symbol_t;
	typedef logic [i2ra_pkg::RADIX_WIDTH-1:0]  radix_t;

	typedef struct packed {
		symbol_t symbol;
		logic    negative;
		logic    last;
	} digit_t;

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 cfg_valid = 1'b0;
	logic                                 cfg_ready;
	radix_t                               cfg_data = '0;
	logic                                 s_axis_tvalid = 1'b0;
	logic                                 s_axis_tready;
	logic [i2ra_pkg::VALUE_BITS-1:0]      s_axis_tdata = '0;  // value
	logic                                 s_axis_tuser = 1'b0; // is_signed
	logic                                 m_axis_tvalid;
	logic                                 m_axis_tready = 1'b0;
	logic [i2ra_pkg::TDATA_OUT_W-1:0]     m_axis_tdata;       // symbol, zero pad
	logic                                 m_axis_tuser;       // negative
	logic                                 m_axis_tlast;

	radix_t                 radix_setting = i2ra_pkg::RADIX_RESET;
	digit_t                 pending_digits[$];
	digit_t                 want;
	int unsigned            mismatches = 0;
	int unsigned            cycle_count = 0;
	int unsigned            src_gap_pct = 25;
	int unsigned            sink_stall_pct = 85;

	integer_to_radix_ascii DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_digits.size() == 0) begin
				$display("%0t: unexpected item data=%h neg=%b last=%b", $time,
					m_axis_tdata, m_axis_tuser, m_axis_tlast);
				mismatches++;
			end else begin
				want = pending_digits.pop_front();
				if (m_axis_tdata !== {1'b0, want.symbol}) begin
					$display("%0t: symbol expected %h actual %h", $time,
						{1'b0, want.symbol}, m_axis_tdata);
					mismatches++;
				end
				if (m_axis_tuser !== want.negative) begin
					$display("%0t: negative expected %b actual %b", $time,
						want.negative, m_axis_tuser);
					mismatches++;
				end
				if (m_axis_tlast !== want.last) begin
					$display("%0t: last expected %b actual %b", $time,
						want.last, m_axis_tlast);
					mismatches++;
				end
			end
		end
	end

	// digits of the magnitude, least significant first, then queued most significant first
	function automatic void predict_digits(input logic [63:0] value, input logic is_signed);
		logic [63:0] base;
		logic [63:0] mag;
		logic        neg;
		symbol_t     rev[$];
		digit_t      d;
		if (radix_setting < 2) begin
			base = 64'd2;
		end else if (radix_setting > 16) begin
			base = 64'd16;
		end else begin
			base = 64'(radix_setting);
		end
		neg = is_signed && value[63];
		mag = neg ? -value : value;
		if (mag == 0) begin
			rev.push_back(symbol_t'(DIGIT_SET[0]));
		end
		while (mag != 0) begin
			rev.push_back(symbol_t'(DIGIT_SET[int'(mag % base)]));
			mag = mag / base;
		end
		for (int k = rev.size() - 1; k >= 0; k--) begin
			d.symbol = rev[k];
			d.negative = neg;
			d.last = (k == 0);
			pending_digits.push_back(d);
		end
	endfunction

	task automatic send_value(input logic [63:0] value, input logic is_signed);
		while ($urandom_range(99) < src_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= value;
		s_axis_tuser <= is_signed;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_digits(value, is_signed);
	endtask

	task automatic wait_for_digits();
		s_axis_tvalid <= 1'b0;
		while (pending_digits.size() != 0) @(posedge clk);
	endtask

	task automatic write_radix(input radix_t r);
		wait_for_digits();
		cfg_valid <= 1'b1;
		cfg_data <= r;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		radix_setting = r;
	endtask

	function automatic logic [63:0] random_value();
		logic [31:0]  w;
		logic [63:0]  v;
		int unsigned  k;
		w = $urandom;
		k = $urandom_range(63);
		case ($urandom_range(6))
			0: v = {$urandom, $urandom};
			1: v = 64'($urandom_range(1000));
			2: v = {{32{w[31]}}, w};
			3: v = {32'd0, w};
			4: v = (64'd1 << k) - 64'($urandom_range(1));
			5: v = -64'($urandom_range(1, 1000));
			default: v = MOST_NEGATIVE ^ 64'($urandom_range(1));
		endcase
		return v;
	endfunction

	task automatic test_reset_radix();
		send_value(64'd0, 1'b1);
		send_value(64'd1, 1'b0);
		send_value('1, 1'b0);
		send_value('1, 1'b1);
		send_value(MOST_NEGATIVE, 1'b1);
		send_value(MOST_NEGATIVE, 1'b0);
		send_value(~MOST_NEGATIVE, 1'b1);
		send_value(64'hffff_ffff_8000_0000, 1'b1);
		send_value(64'd12345, 1'b1);
	endtask

	task automatic test_radix_extremes();
		radix_t radices[7];
		radices = '{5'd0, 5'd1, 5'd2, 5'd16, 5'd17, 5'd31, 5'd7};
		foreach (radices[i]) begin
			write_radix(radices[i]);
			send_value('1, 1'b0);
			send_value(MOST_NEGATIVE, 1'b1);
		end
	endtask

	task automatic test_random_values(input int unsigned count, input int unsigned src_pct,
		input int unsigned sink_pct);
		src_gap_pct = src_pct;
		sink_stall_pct = sink_pct;
		for (int unsigned n = 0; n < count; n++) begin
			if ($urandom_range(29) == 0) begin
				write_radix(($urandom_range(3) == 0) ? radix_t'($urandom_range(31))
					: radix_t'($urandom_range(2, 16)));
			end else if ($urandom_range(39) == 0) begin
				wait_for_digits();
			end
			send_value(random_value(), 1'($urandom_range(1)));
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_radix();
		test_radix_extremes();
		test_random_values(110, 25, 85);
		test_random_values(110, 85, 25);
		test_random_values(130, 0, 0);
		wait_for_digits();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_digits.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
`default_nettype wire
